// ===== rtl/core/i2cme_pkg.sv =====
`default_nettype none
package i2cme_pkg;

  // Line and byte geometry
  localparam int BITS_PER_BYTE = 8;
  localparam int TICK_W        = 16;
  localparam int TIMEOUT_W     = 8;
  localparam int BIT_IDX_W     = 4;
  localparam int CFG_DATA_W    = 16;

  // Register reset values
  localparam logic [TICK_W-1:0]    TICKS_RESET   = 16'd50;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd250;

  // Configuration register indexes
  localparam logic CFG_TICKS   = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Command codes carried by a request
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;
  localparam logic [2:0] ACT_ACK   = 3'd5;
  localparam logic [2:0] ACT_NACK  = 3'd6;
  localparam logic [2:0] ACT_WAIT  = 3'd7;

  // Controller to datapath commands, valid for one accepted tick
  typedef struct packed {
    logic set_scl;
    logic scl_val;
    logic set_sda;
    logic sda_val;
    logic set_en;
    logic en_val;
    logic load_byte;
    logic clr_byte;
    logic shift_out;
    logic shift_in;
    logic clr_bit;
    logic inc_bit;
    logic latch_read;
    logic clr_wait;
    logic inc_wait;
    logic set_timeout;
    logic clr_timeout;
  } dp_cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic bit_last;
    logic wait_over;
    logic next_msb;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/i2cme_dp.sv =====
`default_nettype none
module i2cme_dp
  import i2cme_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_cmd_t                  cmd,
  input  wire logic [BITS_PER_BYTE-1:0] data_byte,
  input  wire logic                     sda_in,
  input  wire logic [TIMEOUT_W-1:0]     ack_timeout,
  output dp_sts_t                       sts,
  output logic                          scl_level,
  output logic                          sda_level,
  output logic                          sda_enable,
  output logic [BITS_PER_BYTE-1:0]      last_read,
  output logic                          timeout_flag
);

  logic [BITS_PER_BYTE-1:0] shift_byte;
  logic [BIT_IDX_W-1:0]     bit_index;
  logic [BIT_IDX_W-1:0]     bit_index_inc;
  logic [TIMEOUT_W-1:0]     wait_ticks;
  logic [TIMEOUT_W:0]       wait_inc;

  // Look ahead at counters for the controller
  assign bit_index_inc = bit_index + 1'b1;
  assign wait_inc      = {1'b0, wait_ticks} + 1'b1;

  assign sts.bit_last  = (bit_index_inc >= BIT_IDX_W'(BITS_PER_BYTE));
  assign sts.wait_over = (wait_inc > {1'b0, ack_timeout});
  assign sts.next_msb  = shift_byte[BITS_PER_BYTE-2];

  // Drive the line levels
  always_ff @(posedge clk) begin
    if (rst) begin
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      sda_enable <= 1'b1;
    end else begin
      if (cmd.set_scl) scl_level  <= cmd.scl_val;
      if (cmd.set_sda) sda_level  <= cmd.sda_val;
      if (cmd.set_en)  sda_enable <= cmd.en_val;
    end
  end

  // Shift the byte in or out, MSB first, and count bits
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte <= '0;
      bit_index  <= '0;
      last_read  <= '0;
    end else begin
      if (cmd.load_byte) begin
        shift_byte <= data_byte;
      end else if (cmd.clr_byte) begin
        shift_byte <= '0;
      end else if (cmd.shift_out) begin
        shift_byte <= {shift_byte[BITS_PER_BYTE-2:0], 1'b0};
      end else if (cmd.shift_in) begin
        shift_byte <= {shift_byte[BITS_PER_BYTE-2:0], sda_in};
      end
      if (cmd.clr_bit) begin
        bit_index <= '0;
      end else if (cmd.inc_bit) begin
        bit_index <= bit_index_inc;
      end
      if (cmd.latch_read) last_read <= shift_byte;
    end
  end

  // Count high polls during an ACK wait and hold the error flag
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks   <= '0;
      timeout_flag <= 1'b0;
    end else begin
      if (cmd.clr_wait) begin
        wait_ticks <= '0;
      end else if (cmd.inc_wait) begin
        wait_ticks <= wait_inc[TIMEOUT_W-1:0];
      end
      if (cmd.clr_timeout) begin
        timeout_flag <= 1'b0;
      end else if (cmd.set_timeout) begin
        timeout_flag <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/i2cme_ctrl.sv =====
`default_nettype none
module i2cme_ctrl
  import i2cme_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [2:0]        action,
  input  wire logic              data_msb,
  input  wire logic              sda_in,
  input  wire logic [TICK_W-1:0] ticks_per_us,
  input  wire dp_sts_t           sts,
  output dp_cmd_t                cmd,
  output logic                   busy,
  output logic                   done
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_ST1  = 4'd1;
  localparam logic [3:0] PH_ST2  = 4'd2;
  localparam logic [3:0] PH_SP1  = 4'd3;
  localparam logic [3:0] PH_SP2  = 4'd4;
  localparam logic [3:0] PH_SP3  = 4'd5;
  localparam logic [3:0] PH_AK1  = 4'd6;
  localparam logic [3:0] PH_AK2  = 4'd7;
  localparam logic [3:0] PH_WRA  = 4'd8;
  localparam logic [3:0] PH_WRB  = 4'd9;
  localparam logic [3:0] PH_WRC  = 4'd10;
  localparam logic [3:0] PH_RDA  = 4'd11;
  localparam logic [3:0] PH_RDB  = 4'd12;
  localparam logic [3:0] PH_WA1  = 4'd13;
  localparam logic [3:0] PH_WAP  = 4'd14;
  localparam logic [3:0] PH_WAE  = 4'd15;

  // Remaining units after the first, for 4, 2 and 1 unit holds
  localparam logic [1:0] UNITS_4 = 2'd3;
  localparam logic [1:0] UNITS_2 = 2'd1;
  localparam logic [1:0] UNITS_1 = 2'd0;

  logic [3:0]        phase;
  logic [3:0]        phase_next;
  logic [TICK_W-1:0] delay_ticks;
  logic [TICK_W-1:0] delay_ticks_next;
  logic [1:0]        units_left;
  logic [1:0]        units_left_next;
  logic              done_next;
  logic [TICK_W-1:0] unit_reload;
  logic              poll;
  logic              enter;
  logic [3:0]        enter_phase;
  logic [1:0]        enter_units;

  // A zero tick count behaves as one tick per unit
  assign unit_reload = (ticks_per_us == '0) ? '0 : ticks_per_us - 1'b1;

  // Sequence the segments of each command
  always_comb begin
    cmd              = '0;
    phase_next       = phase;
    delay_ticks_next = delay_ticks;
    units_left_next  = units_left;
    done_next        = 1'b0;
    poll             = 1'b0;
    enter            = 1'b0;
    enter_phase      = PH_IDLE;
    enter_units      = UNITS_1;

    if (step) begin
      case (phase)
        PH_IDLE: begin
          case (action)
            ACT_START: begin
              cmd.set_en  = 1'b1; cmd.en_val  = 1'b1;
              cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
              cmd.set_sda = 1'b1; cmd.sda_val = 1'b1;
              enter = 1'b1; enter_phase = PH_ST1; enter_units = UNITS_4;
            end
            ACT_STOP: begin
              cmd.set_en  = 1'b1; cmd.en_val  = 1'b1;
              cmd.set_sda = 1'b1; cmd.sda_val = 1'b0;
              enter = 1'b1; enter_phase = PH_SP1; enter_units = UNITS_4;
            end
            ACT_WRITE: begin
              cmd.set_en  = 1'b1; cmd.en_val  = 1'b1;
              cmd.set_scl = 1'b1; cmd.scl_val = 1'b0;
              cmd.set_sda = 1'b1; cmd.sda_val = data_msb;
              cmd.load_byte = 1'b1;
              cmd.clr_bit   = 1'b1;
              enter = 1'b1; enter_phase = PH_WRA; enter_units = UNITS_2;
            end
            ACT_READ: begin
              cmd.set_en  = 1'b1; cmd.en_val  = 1'b0;
              cmd.set_scl = 1'b1; cmd.scl_val = 1'b0;
              cmd.clr_byte = 1'b1;
              cmd.clr_bit  = 1'b1;
              enter = 1'b1; enter_phase = PH_RDA; enter_units = UNITS_2;
            end
            ACT_ACK, ACT_NACK: begin
              cmd.set_en  = 1'b1; cmd.en_val  = 1'b1;
              cmd.set_scl = 1'b1; cmd.scl_val = 1'b0;
              cmd.set_sda = 1'b1; cmd.sda_val = (action == ACT_NACK);
              enter = 1'b1; enter_phase = PH_AK1; enter_units = UNITS_2;
            end
            ACT_WAIT: begin
              cmd.set_en  = 1'b1; cmd.en_val  = 1'b0;
              cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
              cmd.clr_timeout = 1'b1;
              cmd.clr_wait    = 1'b1;
              enter = 1'b1; enter_phase = PH_WA1; enter_units = UNITS_2;
            end
            default: begin
            end
          endcase
        end
        PH_WAP: poll = 1'b1;
        default: begin
          if (delay_ticks != '0) begin
            delay_ticks_next = delay_ticks - 1'b1;
          end else if (units_left != '0) begin
            units_left_next  = units_left - 1'b1;
            delay_ticks_next = unit_reload;
          end else begin
            // Hold is over: move to the next segment
            case (phase)
              PH_ST1: begin
                cmd.set_sda = 1'b1; cmd.sda_val = 1'b0;
                enter = 1'b1; enter_phase = PH_ST2; enter_units = UNITS_4;
              end
              PH_ST2: begin
                cmd.set_scl = 1'b1; cmd.scl_val = 1'b0;
                done_next = 1'b1;
              end
              PH_SP1: begin
                cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
                enter = 1'b1; enter_phase = PH_SP2; enter_units = UNITS_4;
              end
              PH_SP2: begin
                cmd.set_sda = 1'b1; cmd.sda_val = 1'b1;
                enter = 1'b1; enter_phase = PH_SP3; enter_units = UNITS_4;
              end
              PH_AK1: begin
                cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
                enter = 1'b1; enter_phase = PH_AK2; enter_units = UNITS_2;
              end
              PH_AK2: begin
                cmd.set_scl = 1'b1; cmd.scl_val = 1'b0;
                done_next = 1'b1;
              end
              PH_WRA: begin
                cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
                enter = 1'b1; enter_phase = PH_WRB; enter_units = UNITS_2;
              end
              PH_WRB: begin
                cmd.set_scl = 1'b1; cmd.scl_val = 1'b0;
                enter = 1'b1; enter_phase = PH_WRC; enter_units = UNITS_2;
              end
              PH_WRC: begin
                cmd.shift_out = 1'b1;
                cmd.inc_bit   = 1'b1;
                if (sts.bit_last) begin
                  done_next = 1'b1;
                end else begin
                  cmd.set_sda = 1'b1; cmd.sda_val = sts.next_msb;
                  enter = 1'b1; enter_phase = PH_WRA; enter_units = UNITS_2;
                end
              end
              PH_RDA: begin
                cmd.set_scl  = 1'b1; cmd.scl_val = 1'b1;
                cmd.shift_in = 1'b1;
                enter = 1'b1; enter_phase = PH_RDB; enter_units = UNITS_1;
              end
              PH_RDB: begin
                cmd.inc_bit = 1'b1;
                if (sts.bit_last) begin
                  cmd.latch_read = 1'b1;
                  done_next      = 1'b1;
                end else begin
                  cmd.set_scl = 1'b1; cmd.scl_val = 1'b0;
                  enter = 1'b1; enter_phase = PH_RDA; enter_units = UNITS_2;
                end
              end
              PH_WA1: poll = 1'b1;
              default: done_next = 1'b1;
            endcase
          end
        end
      endcase

      // Sample SDA during an ACK wait
      if (poll) begin
        if (!sda_in) begin
          cmd.set_scl = 1'b1; cmd.scl_val = 1'b0;
          enter = 1'b1; enter_phase = PH_WAE; enter_units = UNITS_2;
        end else if (sts.wait_over) begin
          cmd.set_timeout = 1'b1;
          cmd.set_en  = 1'b1; cmd.en_val  = 1'b1;
          cmd.set_sda = 1'b1; cmd.sda_val = 1'b0;
          enter = 1'b1; enter_phase = PH_SP1; enter_units = UNITS_4;
        end else begin
          cmd.inc_wait = 1'b1;
          phase_next   = PH_WAP;
        end
      end

      if (enter) begin
        phase_next       = enter_phase;
        delay_ticks_next = unit_reload;
        units_left_next  = enter_units;
      end
      if (done_next) phase_next = PH_IDLE;
    end
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      delay_ticks <= '0;
      units_left  <= '0;
      done        <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      delay_ticks <= delay_ticks_next;
      units_left  <= units_left_next;
      done        <= done_next;
    end
  end

  assign busy = (phase != PH_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/i2c_master_bit_engine_top.sv =====
// I2C master line engine, stepped once per request.
// Input channel (in_valid / in_stall): each request is one tick carrying the
// sampled SDA level (sda_in) and, when the engine is idle, a command (action)
// with the byte to send (data_byte). Commands that arrive while busy are
// ignored. Output channel (out_valid / out_stall): exactly one result per
// request, holding the SCL/SDA drive, the SDA enable, busy and done flags,
// the last byte read and the ACK timeout flag as they stand after that tick.
// A request accepted at a clock edge has its result valid right after that
// edge. Throughput is one request per cycle; the result is held in the
// engine state registers, so a new request is taken whenever the output
// register is empty or being emptied in the same cycle.
// When the receiver stalls, the result holds and in_stall rises, freezing
// the engine until the result is taken. Phase timing counts requests, not
// clock cycles: each segment lasts 1, 2 or 4 units of ticks_per_us requests.
// Configuration is a write port (cfg_write, cfg_index, cfg_data): index 0 is
// ticks_per_us, index 1 is ack_timeout; write only while idle.
// Synchronous reset returns the engine to idle with SCL and SDA driven high,
// ticks_per_us at 50, ack_timeout at 250 and no result pending.
`default_nettype none
module i2c_master_bit_engine_top
  import i2cme_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               action,
  input  wire logic [BITS_PER_BYTE-1:0] data_byte,
  input  wire logic                     sda_in,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          scl_out,
  output logic                          sda_out,
  output logic                          sda_drive,
  output logic                          busy_res,
  output logic                          done_res,
  output logic [BITS_PER_BYTE-1:0]      read_data,
  output logic                          ack_error,
  input  wire logic                     cfg_write,
  input  wire logic                     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  logic [TICK_W-1:0]    ticks_per_us;
  logic [TIMEOUT_W-1:0] ack_timeout;
  logic                 step;
  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic                 scl_level;
  logic                 sda_level;
  logic                 sda_enable;

  // Take a request unless an untaken result is stalled
  assign in_stall = out_valid & out_stall;
  assign step     = in_valid & ~in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= TICKS_RESET;
      ack_timeout  <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TICKS:   ticks_per_us <= cfg_data;
        CFG_TIMEOUT: ack_timeout  <= cfg_data[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  i2cme_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .action       (action),
    .data_msb     (data_byte[BITS_PER_BYTE-1]),
    .sda_in       (sda_in),
    .ticks_per_us (ticks_per_us),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy_res),
    .done         (done_res)
  );

  i2cme_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .sda_in       (sda_in),
    .ack_timeout  (ack_timeout),
    .sts          (sts),
    .scl_level    (scl_level),
    .sda_level    (sda_level),
    .sda_enable   (sda_enable),
    .last_read    (read_data),
    .timeout_flag (ack_error)
  );

  // Released SDA reads as the bus idle level
  assign scl_out   = scl_level;
  assign sda_drive = sda_enable;
  assign sda_out   = sda_enable ? sda_level : 1'b1;

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done result while still busy");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request gave no result");

  a_timeout_starts_stop: assert property (@(posedge clk) disable iff (rst)
    $rose(ack_error) |-> sda_drive && !sda_out && busy_res)
    else $error("ACK timeout did not begin a stop");
`endif

endmodule
`default_nettype wire
